// ----- hdl/y2r_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, BT.601 coefficients and channel helpers for the YUYV to RGB
// converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int LANES   = 2;
    localparam int COEF_W  = 13;
    localparam int OFF_W   = 10;
    localparam int TERM_W  = 21;
    localparam int SUM_W   = 22;
    localparam int FRAC_W  = 10;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 24;

    localparam logic signed [OFF_W-1:0]  LUMA_OFFSET   = 10'sd16;
    localparam logic signed [OFF_W-1:0]  CHROMA_OFFSET = 10'sd128;
    localparam logic signed [COEF_W-1:0] LUMA_GAIN     = 13'sd1192;
    localparam logic signed [COEF_W-1:0] RED_V_GAIN    = 13'sd1634;
    localparam logic signed [COEF_W-1:0] GREEN_U_GAIN  = 13'sd400;
    localparam logic signed [COEF_W-1:0] GREEN_V_GAIN  = 13'sd833;
    localparam logic signed [COEF_W-1:0] BLUE_U_GAIN   = 13'sd2066;

    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    typedef struct packed {
        logic s1_en;
        logic fmt;
    } y2r_ctrl_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] r_term;
        logic signed [TERM_W-1:0] g_term;
        logic signed [TERM_W-1:0] b_term;
    } y2r_terms_t;

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] s);
        logic [CH_W-1:0] res;
        if (s[SUM_W-1]) begin
            res = '0;
        end else if (|s[SUM_W-2:FRAC_W+CH_W]) begin
            res = '1;
        end else begin
            res = s[FRAC_W+CH_W-1:FRAC_W];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] pack_pixel(input logic fmt,
                                                    input logic [CH_W-1:0] r,
                                                    input logic [CH_W-1:0] g,
                                                    input logic [CH_W-1:0] b);
        logic [PIX_W-1:0] res;
        if (fmt == FMT_RGB888) begin
            res = {r, g, b};
        end else begin
            res = {8'h00, r[7:3], g[7:2], b[7:3]};
        end
        return res;
    endfunction

endpackage

// ----- hdl/yuyv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// BT.601 YUYV to RGB888 / RGB565 converter, two pixel lanes per group.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one YUYV group per request (two lumas, shared U and V,
//   frame end marker). Output channel m_*: two packed pixels plus the copied
//   frame end marker, one request per input request, in order.
//   cfg_wr_en / cfg_wr_data set the output format (0 RGB565, 1 RGB888);
//   write only while no request is in flight.
//   m_valid rises after the stage-one and output registers take the group.
//   Throughput: one group per cycle while m_ready is high; the stage-one
//   multipliers and the output register are the two pipeline stages.
//   Reset (aresetn low, synchronous) empties the pipeline and selects RGB565.
//   When the receiver stalls, the output register holds its request, the
//   first stage still takes one more group, then s_ready drops until
//   m_ready returns; empty stages close up so no cycle is lost.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core
    import y2r_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CH_W-1:0]   s_first_luma,
    input  logic [CH_W-1:0]   s_chroma_blue,
    input  logic [CH_W-1:0]   s_second_luma,
    input  logic [CH_W-1:0]   s_chroma_red,
    input  logic              s_frame_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_first_pixel,
    output logic [PIX_W-1:0]  m_second_pixel,
    output logic              m_frame_end_out
);

    logic             output_format_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_frame_end_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [PIX_W-1:0] first_pixel_reg;
    logic [PIX_W-1:0] second_pixel_reg;
    logic             frame_end_out_reg;
    logic             s1_en;
    logic             s2_en;
    y2r_ctrl_t        ctrl;
    y2r_terms_t       terms;
    logic [CH_W-1:0]  lane_luma  [LANES];
    logic [PIX_W-1:0] lane_pixel [LANES];

    always_comb begin
        s2_en         = s1_valid_reg && (!m_valid_reg || m_ready);
        s_ready       = !s1_valid_reg || s2_en;
        s1_en         = s_valid && s_ready;
        s1_valid_next = s1_en ? 1'b1 : (s2_en ? 1'b0 : s1_valid_reg);
        m_valid_next  = s2_en ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        ctrl.s1_en    = s1_en;
        ctrl.fmt      = output_format_reg;
        lane_luma[0]  = s_first_luma;
        lane_luma[1]  = s_second_luma;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_format_reg <= FMT_RGB565;
            s1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                output_format_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    y2r_chroma u_chroma (
        .aclk        (aclk),
        .s1_en       (s1_en),
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .terms       (terms)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        y2r_lane u_lane (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .luma  (lane_luma[i]),
            .terms (terms),
            .pixel (lane_pixel[i])
        );
    end

    // merge lanes into the output register
    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_frame_end_reg <= s_frame_end;
        end
        if (s2_en) begin
            first_pixel_reg   <= lane_pixel[0];
            second_pixel_reg  <= lane_pixel[1];
            frame_end_out_reg <= s1_frame_end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_first_pixel   = first_pixel_reg;
    assign m_second_pixel  = second_pixel_reg;
    assign m_frame_end_out = frame_end_out_reg;

endmodule

// ----- hdl/y2r_chroma.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma
// Shared chroma products for one YUYV group, registered for the lanes.
// ----------------------------------------------------------------------------
module y2r_chroma
    import y2r_pkg::*;
(
    input  logic             aclk,
    input  logic             s1_en,
    input  logic [CH_W-1:0]  chroma_blue,
    input  logic [CH_W-1:0]  chroma_red,
    output y2r_terms_t       terms
);

    logic signed [OFF_W-1:0] u_off;
    logic signed [OFF_W-1:0] v_off;
    y2r_terms_t              terms_reg;
    y2r_terms_t              terms_next;

    always_comb begin
        u_off = $signed({2'b00, chroma_blue}) - CHROMA_OFFSET;
        v_off = $signed({2'b00, chroma_red}) - CHROMA_OFFSET;
        terms_next.r_term = TERM_W'(v_off) * TERM_W'(RED_V_GAIN);
        terms_next.g_term = TERM_W'(u_off) * TERM_W'(GREEN_U_GAIN)
                          + TERM_W'(v_off) * TERM_W'(GREEN_V_GAIN);
        terms_next.b_term = TERM_W'(u_off) * TERM_W'(BLUE_U_GAIN);
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ----- hdl/y2r_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_lane
// One pixel lane: scaled luma, channel sums, clamp and packing.
// ----------------------------------------------------------------------------
module y2r_lane
    import y2r_pkg::*;
(
    input  logic              aclk,
    input  y2r_ctrl_t         ctrl,
    input  logic [CH_W-1:0]   luma,
    input  y2r_terms_t        terms,
    output logic [PIX_W-1:0]  pixel
);

    logic signed [OFF_W-1:0]  y_off;
    logic signed [TERM_W-1:0] base_reg;
    logic signed [TERM_W-1:0] base_next;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  g_sum;
    logic signed [SUM_W-1:0]  b_sum;

    always_comb begin
        y_off     = $signed({2'b00, luma}) - LUMA_OFFSET;
        base_next = TERM_W'(y_off) * TERM_W'(LUMA_GAIN);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s1_en) begin
            base_reg <= base_next;
        end
    end

    always_comb begin
        r_sum = SUM_W'(base_reg) + SUM_W'(terms.r_term);
        g_sum = SUM_W'(base_reg) - SUM_W'(terms.g_term);
        b_sum = SUM_W'(base_reg) + SUM_W'(terms.b_term);
        pixel = pack_pixel(ctrl.fmt, clamp_ch(r_sum), clamp_ch(g_sum), clamp_ch(b_sum));
    end

endmodule

// ----- hdl/y2r_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks on the converter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module y2r_checker
    import y2r_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [PIX_W-1:0] m_first_pixel,
    input logic [PIX_W-1:0] m_second_pixel,
    input logic             m_frame_end_out
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output request present after reset");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_pixel)
                                && $stable(m_second_pixel) && $stable(m_frame_end_out))
        else $error("stalled output request changed");

endmodule

bind yuyv_to_rgb_converter_core y2r_checker u_y2r_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_first_pixel   (m_first_pixel),
    .m_second_pixel  (m_second_pixel),
    .m_frame_end_out (m_frame_end_out)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUYV to RGB converter core. A stimulus table
// of corner groups runs in both output formats, then random groups run in
// phases with sender and receiver idling at different rates. Each accepted
// group's expected pair is typed in its row or made by a BT.601 fixed-point
// predictor; output requests are checked field by field, oldest pair first.
// ----------------------------------------------------------------------------
module tb_top
    import y2r_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 8;
    localparam int NUM_ROWS       = 14;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 250;

    localparam int Y_OFFSET  = 16;
    localparam int C_OFFSET  = 128;
    localparam int Y_GAIN    = 1192;
    localparam int RV_GAIN   = 1634;
    localparam int GU_GAIN   = 400;
    localparam int GV_GAIN   = 833;
    localparam int BU_GAIN   = 2066;
    localparam int FRAC_BITS = 10;
    localparam int CH_MAX    = 255;

    typedef struct {
        logic [CH_W-1:0] y0;
        logic [CH_W-1:0] cb;
        logic [CH_W-1:0] y1;
        logic [CH_W-1:0] cr;
        logic            fe;
    } yuyv_group_t;

    typedef struct {
        logic [PIX_W-1:0] p0;
        logic [PIX_W-1:0] p1;
        logic             fe;
    } pixel_pair_t;

    typedef struct packed {
        logic [CH_W-1:0]  y0;
        logic [CH_W-1:0]  cb;
        logic [CH_W-1:0]  y1;
        logic [CH_W-1:0]  cr;
        logic             fe;
        logic             known;
        logic [PIX_W-1:0] p0_565;
        logic [PIX_W-1:0] p1_565;
        logic [PIX_W-1:0] p0_888;
        logic [PIX_W-1:0] p1_888;
    } stim_row_t;

    stim_row_t stim_rows [NUM_ROWS] = '{
        '{8'd16,  8'd128, 8'd16,  8'd128, 1'b0, 1'b1,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{8'd255, 8'd128, 8'd255, 8'd128, 1'b1, 1'b1,
          24'h00FFFF, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF},
        '{8'd0,   8'd128, 8'd0,   8'd128, 1'b0, 1'b1,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{8'd16,  8'd128, 8'd255, 8'd128, 1'b1, 1'b1,
          24'h000000, 24'h00FFFF, 24'h000000, 24'hFFFFFF},
        '{8'd235, 8'd128, 8'd16,  8'd128, 1'b0, 1'b1,
          24'h00FFFF, 24'h000000, 24'hFEFEFE, 24'h000000},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd128, 8'd255, 8'd128, 8'd0,   1'b1, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd170, 8'd60,  8'd200, 8'd190, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{8'd1,   8'd1,   8'd254, 8'd254, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0}
    };

    logic phase_fmt [NUM_PHASES] = '{FMT_RGB888, FMT_RGB565, FMT_RGB888,
                                     FMT_RGB565, FMT_RGB888, FMT_RGB565};
    int   phase_tx  [NUM_PHASES] = '{0, 71, 0, 27, 71, 0};
    int   phase_rx  [NUM_PHASES] = '{0, 0, 71, 27, 0, 71};

    logic             aclk            = 1'b0;
    logic             aresetn         = 1'b0;
    logic             cfg_wr_en       = 1'b0;
    logic             cfg_wr_data     = 1'b0;
    logic             s_valid         = 1'b0;
    logic             s_ready;
    logic [CH_W-1:0]  s_first_luma    = '0;
    logic [CH_W-1:0]  s_chroma_blue   = '0;
    logic [CH_W-1:0]  s_second_luma   = '0;
    logic [CH_W-1:0]  s_chroma_red    = '0;
    logic             s_frame_end     = 1'b0;
    logic             m_valid;
    logic             m_ready         = 1'b0;
    logic [PIX_W-1:0] m_first_pixel;
    logic [PIX_W-1:0] m_second_pixel;
    logic             m_frame_end_out;

    pixel_pair_t pixel_q [$];
    logic        fmt_cur      = FMT_RGB565;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    bit          hold_req     = 1'b0;
    int          hold_left    = 0;
    int          idle_cycles  = 0;
    int          mismatches   = 0;

    yuyv_to_rgb_converter_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_luma    (s_first_luma),
        .s_chroma_blue   (s_chroma_blue),
        .s_second_luma   (s_second_luma),
        .s_chroma_red    (s_chroma_red),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_pixel   (m_first_pixel),
        .m_second_pixel  (m_second_pixel),
        .m_frame_end_out (m_frame_end_out)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [CH_W-1:0] saturate_channel(input int sum);
        int q;
        if (sum < 0) begin
            return '0;
        end
        q = sum >>> FRAC_BITS;
        if (q > CH_MAX) begin
            return '1;
        end
        return q[CH_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] convert_pixel(input logic fmt,
                                                       input logic [CH_W-1:0] y,
                                                       input int rt, input int gt,
                                                       input int bt);
        int              base;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        base = Y_GAIN * (int'(y) - Y_OFFSET);
        r = saturate_channel(base + rt);
        g = saturate_channel(base - gt);
        b = saturate_channel(base + bt);
        if (fmt == FMT_RGB888) begin
            return {r, g, b};
        end
        return {8'h00, r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic pixel_pair_t convert_group(input logic fmt, input yuyv_group_t grp);
        pixel_pair_t res;
        int          u;
        int          v;
        u = int'(grp.cb) - C_OFFSET;
        v = int'(grp.cr) - C_OFFSET;
        res.p0 = convert_pixel(fmt, grp.y0, RV_GAIN * v, GU_GAIN * u + GV_GAIN * v,
                               BU_GAIN * u);
        res.p1 = convert_pixel(fmt, grp.y1, RV_GAIN * v, GU_GAIN * u + GV_GAIN * v,
                               BU_GAIN * u);
        res.fe = grp.fe;
        return res;
    endfunction

    function automatic logic [CH_W-1:0] pick_byte();
        logic [CH_W-1:0] corners [10] = '{8'd0, 8'd1, 8'd16, 8'd127, 8'd128,
                                          8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
        if ($urandom_range(3) == 0) begin
            return corners[4'($urandom_range(9))];
        end
        return CH_W'($urandom_range(255));
    endfunction

    task automatic send_group(input yuyv_group_t grp, input bit typed,
                              input pixel_pair_t typed_pair);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_luma  <= grp.y0;
        s_chroma_blue <= grp.cb;
        s_second_luma <= grp.y1;
        s_chroma_red  <= grp.cr;
        s_frame_end   <= grp.fe;
        do @(posedge aclk); while (!s_ready);
        pixel_q.push_back(typed ? typed_pair : convert_group(fmt_cur, grp));
    endtask

    task automatic send_table();
        yuyv_group_t grp;
        pixel_pair_t typed_pair;
        for (int i = 0; i < NUM_ROWS; i++) begin
            grp = '{stim_rows[i].y0, stim_rows[i].cb, stim_rows[i].y1,
                    stim_rows[i].cr, stim_rows[i].fe};
            if (fmt_cur == FMT_RGB888) begin
                typed_pair = '{stim_rows[i].p0_888, stim_rows[i].p1_888, stim_rows[i].fe};
            end else begin
                typed_pair = '{stim_rows[i].p0_565, stim_rows[i].p1_565, stim_rows[i].fe};
            end
            send_group(grp, stim_rows[i].known, typed_pair);
        end
    endtask

    task automatic send_random(input int count);
        yuyv_group_t grp;
        pixel_pair_t none;
        none = '{'0, '0, 1'b0};
        for (int i = 0; i < count; i++) begin
            grp.y0 = pick_byte();
            grp.cb = pick_byte();
            grp.y1 = pick_byte();
            grp.cr = pick_byte();
            grp.fe = ($urandom_range(7) == 0);
            send_group(grp, 1'b0, none);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_format(input logic fmt);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fmt;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        fmt_cur      = fmt;
    endtask

    task automatic note_field(input string field, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
        if (want !== got) begin
            if (mismatches < MAX_REPORTS) begin
                $display("mismatch %s: expected %h, got %h", field, want, got);
            end
            mismatches++;
        end
    endtask

    // hold off when asked, otherwise stall at the phase rate
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = RX_HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pixel_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected request: %h %h %b",
                             m_first_pixel, m_second_pixel, m_frame_end_out);
                end
                mismatches++;
            end else begin
                want = pixel_q.pop_front();
                note_field("first_pixel", want.p0, m_first_pixel);
                note_field("second_pixel", want.p1, m_second_pixel);
                note_field("frame_end_out", PIX_W'(want.fe), PIX_W'(m_frame_end_out));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_table();
        drain_results();
        write_format(FMT_RGB888);
        tx_idle_pct  = 27;
        rx_stall_pct = 27;
        send_table();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_format(phase_fmt[ph]);
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            send_random(PHASE_ITEMS);
        end

        // fill the pipeline against a stalled receiver
        drain_results();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        send_random(40);
        drain_results();
        send_random(20);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/y2r_pkg.sv
hdl/y2r_chroma.sv
hdl/y2r_lane.sv
hdl/yuyv_to_rgb_converter_core.sv
hdl/y2r_checker.sv
tb/tb_top.sv
